[src/ccd_pkg.sv]
// Shared types, constants and register codes of the circular cosine height brush.
`timescale 1ns / 1ps
package ccd_pkg;

  // Fixed-point constants, Q2.30
  localparam logic [31:0] Q30One    = 32'h4000_0000;
  localparam logic [31:0] AngK      = 32'd3371549327;  // 3.14 truncated to Q2.30
  localparam logic [31:0] HalfPiQ30 = 32'd1686629713;
  localparam logic [31:0] PiQ30     = 32'd3373259426;

  // Taylor series divisors of the cosine and their reciprocals, floor(2^32 / k)
  localparam int PolySteps = 5;
  localparam logic [6:0] PolyDiv [PolySteps] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [31:0] PolyRecip [PolySteps] = '{
    32'((64'd1 << 32) / 64'd90),
    32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd2)
  };

  // Configuration register indexes
  typedef enum logic [2:0] {
    RegCenterX     = 3'd0,
    RegCenterZ     = 3'd1,
    RegRadius      = 3'd2,
    RegDisplace    = 3'd3,
    RegAdditive    = 3'd4,
    RegHeightScale = 3'd5,
    RegMaxHeight   = 3'd6
  } reg_idx_e;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
    logic [31:0]        disp_mag;   // |displacement|
    logic               disp_neg;   // displacement < 0
    logic               additive;
    logic [31:0]        scale;      // height_scale, a zero write stored as 1 LSB
    logic [15:0]        max_height;
  } cfg_t;

  // Per-item sideband carried along the pipeline
  typedef struct packed {
    logic        in_circle;
    logic [15:0] raw;
  } side_t;

endpackage

[src/circular_cosine_height_displace.sv]
// Top level: configuration registers, brush pipeline and output skid buffer.
// Each result passes the distance, bump and height pipelines into the output register.
// Throughput: one sample per cycle; the pipeline advances whenever the skid
// buffer is empty, so a single stalled result does not hold the input.
// Reset: all valid bits clear; configuration returns to centre 0, radius 1.0,
// displacement 0, additive mode, scale 1.0 and max height 65535.
`timescale 1ns / 1ps
module circular_cosine_height_displace import ccd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // raw_height[15:0], sample_x[47:16], sample_z[79:48]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // new_height[15:0]
  output logic [0:0]  m_axis_tuser    // inside_res[0]
);

  cfg_t cfg_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x   <= '0;
      cfg_q.center_z   <= '0;
      cfg_q.radius     <= 31'd65536;
      cfg_q.disp_mag   <= '0;
      cfg_q.disp_neg   <= 1'b0;
      cfg_q.additive   <= 1'b1;
      cfg_q.scale      <= 32'd65536;
      cfg_q.max_height <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegCenterX:  cfg_q.center_x <= cfg_data_i;
        RegCenterZ:  cfg_q.center_z <= cfg_data_i;
        RegRadius:   cfg_q.radius   <= cfg_data_i[30:0];
        RegDisplace: begin
          cfg_q.disp_neg <= cfg_data_i[31];
          cfg_q.disp_mag <= cfg_data_i[31] ? 32'(-cfg_data_i) : cfg_data_i;
        end
        RegAdditive:    cfg_q.additive <= cfg_data_i[0];
        RegHeightScale: cfg_q.scale <= (cfg_data_i == '0) ? 32'd1 : cfg_data_i;
        RegMaxHeight:   cfg_q.max_height <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic        en;
  logic        skid_v_q, out_v_q;
  logic        d_valid, c_valid, h_valid, h_ovf;
  side_t       d_side, c_side, h_side;
  logic [30:0] d_dist;
  logic [31:0] c_bmag;
  logic [16:0] h_quo;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  ccd_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid),
    .raw_i      (s_axis_tdata[15:0]),
    .sample_x_i (s_axis_tdata[47:16]),
    .sample_z_i (s_axis_tdata[79:48]),
    .cfg_i      (cfg_q),
    .valid_o    (d_valid),
    .side_o     (d_side),
    .dist_o     (d_dist)
  );

  ccd_cos u_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .side_i  (d_side),
    .dist_i  (d_dist),
    .cfg_i   (cfg_q),
    .valid_o (c_valid),
    .side_o  (c_side),
    .bmag_o  (c_bmag)
  );

  ccd_height u_height (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid),
    .side_i  (c_side),
    .bmag_i  (c_bmag),
    .cfg_i   (cfg_q),
    .valid_o (h_valid),
    .side_o  (h_side),
    .ovf_o   (h_ovf),
    .quo_o   (h_quo)
  );

  // Clamp inside samples, pass outside samples through
  logic [15:0] res_height;
  always_comb begin
    if (!h_side.in_circle) begin
      res_height = h_side.raw;
    end else if (h_ovf || (h_quo > {1'b0, cfg_q.max_height})) begin
      res_height = cfg_q.max_height;
    end else begin
      res_height = h_quo[15:0];
    end
  end

  // Output register with one skid entry
  logic        out_v_d, skid_v_d, out_load, skid_load, from_skid;
  logic [15:0] out_h_q, skid_h_q;
  logic        out_in_q, skid_in_q;

  always_comb begin
    out_v_d   = out_v_q;
    skid_v_d  = skid_v_q;
    out_load  = 1'b0;
    skid_load = 1'b0;
    from_skid = 1'b0;
    if (skid_v_q) begin
      if (m_axis_tready) begin
        from_skid = 1'b1;
        skid_v_d  = 1'b0;
      end
    end else begin
      if (out_v_q && m_axis_tready) out_v_d = 1'b0;
      if (h_valid) begin
        if (!out_v_q || m_axis_tready) begin
          out_load = 1'b1;
          out_v_d  = 1'b1;
        end else begin
          skid_load = 1'b1;
          skid_v_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (from_skid) begin
      out_h_q  <= skid_h_q;
      out_in_q <= skid_in_q;
    end else if (out_load) begin
      out_h_q  <= res_height;
      out_in_q <= h_side.in_circle;
    end
    if (skid_load) begin
      skid_h_q  <= res_height;
      skid_in_q <= h_side.in_circle;
    end
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_h_q;
  assign m_axis_tuser[0] = out_in_q;

endmodule

[src/ccd_dist.sv]
// Distance stage: offsets, squares, inside test and pipelined square root.
`timescale 1ns / 1ps
module ccd_dist import ccd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [15:0]        raw_i,
  input  logic signed [31:0] sample_x_i,
  input  logic signed [31:0] sample_z_i,
  input  cfg_t               cfg_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic [30:0]        dist_o
);

  localparam int SqSteps = 31;

  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] root;
    logic [61:0] rest;
    side_t       side;
  } sq_t;

  // Offsets and per-axis bound check
  logic signed [32:0] dx, dz;
  logic [32:0] ax, az;
  logic near;
  assign dx = 33'(sample_x_i) - 33'(cfg_i.center_x);
  assign dz = 33'(sample_z_i) - 33'(cfg_i.center_z);
  assign ax = dx[32] ? 33'(-dx) : 33'(dx);
  assign az = dz[32] ? 33'(-dz) : 33'(dz);
  assign near = (ax < {2'b00, cfg_i.radius}) && (az < {2'b00, cfg_i.radius});

  logic        g1_v_q, g2_v_q;
  logic [30:0] ax_q, az_q;
  logic        near1_q, near2_q;
  logic [15:0] raw1_q, raw2_q;
  logic [61:0] ax2_q, az2_q, r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_v_q <= 1'b0;
      g2_v_q <= 1'b0;
    end else if (en_i) begin
      g1_v_q <= valid_i;
      g2_v_q <= g1_v_q;
    end
  end

  // Register offsets, then squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q    <= ax[30:0];
      az_q    <= az[30:0];
      near1_q <= near;
      raw1_q  <= raw_i;
      ax2_q   <= 62'(ax_q) * 62'(ax_q);
      az2_q   <= 62'(az_q) * 62'(az_q);
      r2_q    <= 62'(cfg_i.radius) * 62'(cfg_i.radius);
      near2_q <= near1_q;
      raw2_q  <= raw1_q;
    end
  end

  // Sum of squares and strict compare with radius squared
  logic [62:0] sum2;
  sq_t   sq0_d;
  assign sum2 = 63'(ax2_q) + 63'(az2_q);
  always_comb begin
    sq0_d.rem            = '0;
    sq0_d.root           = '0;
    sq0_d.rest           = sum2[61:0];
    sq0_d.side.raw       = raw2_q;
    sq0_d.side.in_circle = near2_q && (sum2 < {1'b0, r2_q});
  end

  sq_t  sq_q [SqSteps+1];
  logic sv_q [SqSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (en_i) sv_q[0] <= g2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) sq_q[0] <= sq0_d;
  end

  // One root bit per stage
  for (genvar s = 0; s < SqSteps; s++) begin : g_sqrt
    logic [33:0] r4, trial;
    sq_t sq_d;
    always_comb begin
      r4    = {sq_q[s].rem, sq_q[s].rest[61:60]};
      trial = {1'b0, sq_q[s].root, 2'b01};
      sq_d      = sq_q[s];
      sq_d.rest = {sq_q[s].rest[59:0], 2'b00};
      if (r4 >= trial) begin
        sq_d.rem  = 32'(r4 - trial);
        sq_d.root = {sq_q[s].root[29:0], 1'b1};
      end else begin
        sq_d.rem  = r4[31:0];
        sq_d.root = {sq_q[s].root[29:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[s+1] <= 1'b0;
      else if (en_i) sv_q[s+1] <= sv_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) sq_q[s+1] <= sq_d;
    end
  end

  assign valid_o = sv_q[SqSteps];
  assign side_o  = sq_q[SqSteps].side;
  assign dist_o  = sq_q[SqSteps].root;

endmodule

[src/ccd_cos.sv]
// Bump stage: normalised distance, angle, cosine series and bump magnitude.
`timescale 1ns / 1ps
module ccd_cos import ccd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  side_t       side_i,
  input  logic [30:0] dist_i,
  input  cfg_t        cfg_i,
  output logic        valid_o,
  output side_t       side_o,
  output logic [31:0] bmag_o
);

  localparam int DivSteps  = 16;
  localparam int PolyRegs  = 3 * PolySteps;

  typedef struct packed {
    logic [30:0] rem;
    logic [15:0] quo;
    side_t       side;
  } dv_t;

  typedef struct packed {
    logic [31:0] y;
    logic [30:0] t;
    logic [31:0] n;
    logic [31:0] q0;
    logic        cneg;
    side_t       side;
  } pl_t;

  // Normalised distance d = dist * 2^16 / radius, one quotient bit per stage
  dv_t  dv_q [DivSteps+1];
  logic dv_v [DivSteps+1];
  always_comb begin
    dv_q[0].rem  = dist_i;
    dv_q[0].quo  = '0;
    dv_q[0].side = side_i;
    dv_v[0]      = valid_i;
  end

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    logic [31:0] r2;
    dv_t dv_d;
    always_comb begin
      r2   = {dv_q[s].rem, 1'b0};
      dv_d = dv_q[s];
      if (r2 >= {1'b0, cfg_i.radius}) begin
        dv_d.rem = 31'(r2 - {1'b0, cfg_i.radius});
        dv_d.quo = {dv_q[s].quo[14:0], 1'b1};
      end else begin
        dv_d.rem = r2[30:0];
        dv_d.quo = {dv_q[s].quo[14:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v[s+1] <= 1'b0;
      else if (en_i) dv_v[s+1] <= dv_v[s];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) dv_q[s+1] <= dv_d;
    end
  end

  // Angle, fold into the first quadrant, square
  logic [47:0] ang_prod;
  logic [31:0] a_q;
  logic [30:0] x_q;
  logic [61:0] xx;
  logic [31:0] y_q;
  logic        cneg_x_q, cneg_y_q;
  side_t       side_a_q, side_x_q, side_y_q;
  logic        a_v_q, x_v_q, y_v_q;

  assign ang_prod = 48'(dv_q[DivSteps].quo) * 48'(AngK);
  assign xx       = 62'(x_q) * 62'(x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      x_v_q <= 1'b0;
      y_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= dv_v[DivSteps];
      x_v_q <= a_v_q;
      y_v_q <= x_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q      <= ang_prod[47:16];
      side_a_q <= dv_q[DivSteps].side;
      if (a_q <= HalfPiQ30) begin
        x_q      <= a_q[30:0];
        cneg_x_q <= 1'b0;
      end else begin
        x_q      <= 31'(PiQ30 - a_q);
        cneg_x_q <= 1'b1;
      end
      side_x_q <= side_a_q;
      y_q      <= xx[61:30];
      cneg_y_q <= cneg_x_q;
      side_y_q <= side_x_q;
    end
  end

  // Horner series: multiply, reciprocal multiply, correct and subtract
  pl_t  pl_q [PolyRegs+1];
  logic pl_v [PolyRegs+1];
  always_comb begin
    pl_q[0].y    = y_q;
    pl_q[0].t    = Q30One[30:0];
    pl_q[0].n    = '0;
    pl_q[0].q0   = '0;
    pl_q[0].cneg = cneg_y_q;
    pl_q[0].side = side_y_q;
    pl_v[0]      = y_v_q;
  end

  for (genvar j = 0; j < PolyRegs; j++) begin : g_poly
    localparam int K  = j / 3;
    localparam int Ph = j % 3;
    pl_t pl_d;
    if (Ph == 0) begin : g_mul
      logic [62:0] yt;
      assign yt = 63'(pl_q[j].y) * 63'(pl_q[j].t);
      always_comb begin
        pl_d   = pl_q[j];
        pl_d.n = yt[61:30];
      end
    end else if (Ph == 1) begin : g_recip
      logic [63:0] nm;
      assign nm = 64'(pl_q[j].n) * 64'(PolyRecip[K]);
      always_comb begin
        pl_d    = pl_q[j];
        pl_d.q0 = nm[63:32];
      end
    end else begin : g_fix
      logic [38:0] qk;
      logic [31:0] r, p;
      assign qk = 39'(pl_q[j].q0) * 39'(PolyDiv[K]);
      always_comb begin
        r    = pl_q[j].n - qk[31:0];
        p    = (r >= 32'(PolyDiv[K])) ? pl_q[j].q0 + 32'd1 : pl_q[j].q0;
        pl_d = pl_q[j];
        pl_d.t = (p > Q30One) ? 31'd0 : 31'(Q30One - p);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) pl_v[j+1] <= 1'b0;
      else if (en_i) pl_v[j+1] <= pl_v[j];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) pl_q[j+1] <= pl_d;
    end
  end

  // Raised cosine weight, then scale by |displacement|
  logic [31:0] c_ext, w_q, bmag_q;
  logic [63:0] bprod;
  side_t       side_w_q, side_b_q;
  logic        w_v_q, b_v_q;

  assign c_ext = 32'(pl_q[PolyRegs].t);
  assign bprod = 64'(cfg_i.disp_mag) * 64'(w_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else if (en_i) begin
      w_v_q <= pl_v[PolyRegs];
      b_v_q <= w_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (pl_q[PolyRegs].cneg) begin
        w_q <= (c_ext > Q30One) ? 32'd0 : Q30One - c_ext;
      end else begin
        w_q <= Q30One + c_ext;
      end
      side_w_q <= pl_q[PolyRegs].side;
      bmag_q   <= bprod[62:31];
      side_b_q <= side_w_q;
    end
  end

  assign valid_o = b_v_q;
  assign side_o  = side_b_q;
  assign bmag_o  = bmag_q;

endmodule

[src/ccd_height.sv]
// Height stage: base height, bump combine and pipelined divide by the scale.
`timescale 1ns / 1ps
module ccd_height import ccd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  side_t       side_i,
  input  logic [31:0] bmag_i,
  input  cfg_t        cfg_i,
  output logic        valid_o,
  output side_t       side_o,
  output logic        ovf_o,
  output logic [16:0] quo_o
);

  localparam int QBits = 17;

  typedef struct packed {
    logic [31:0]      rem;
    logic [QBits-1:0] low;
    logic [QBits-1:0] quo;
    logic             ovf;
    side_t            side;
  } hd_t;

  // Base height and bump
  logic [47:0] base_q;
  logic [31:0] bmag_q;
  logic [48:0] total_q;
  side_t       side1_q, side2_q;
  logic        h1_v_q, h2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_v_q <= 1'b0;
      h2_v_q <= 1'b0;
    end else if (en_i) begin
      h1_v_q <= valid_i;
      h2_v_q <= h1_v_q;
    end
  end

  logic [48:0] total_d;
  always_comb begin
    if (cfg_i.additive) begin
      if (cfg_i.disp_neg) begin
        total_d = (base_q <= 48'(bmag_q)) ? 49'd0 : 49'(base_q - 48'(bmag_q));
      end else begin
        total_d = 49'(base_q) + 49'(bmag_q);
      end
    end else begin
      total_d = cfg_i.disp_neg ? 49'd0 : 49'(bmag_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q  <= 48'(side_i.raw) * 48'(cfg_i.scale);
      bmag_q  <= bmag_i;
      side1_q <= side_i;
      total_q <= total_d;
      side2_q <= side1_q;
    end
  end

  // Overflow check and start of the long division
  hd_t  hd_q [QBits+1];
  logic hv_q [QBits+1];
  hd_t  hd0_d;
  always_comb begin
    hd0_d.rem  = total_q[48:17];
    hd0_d.low  = total_q[16:0];
    hd0_d.quo  = '0;
    hd0_d.ovf  = total_q >= {cfg_i.scale, 17'd0};
    hd0_d.side = side2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hv_q[0] <= 1'b0;
    else if (en_i) hv_q[0] <= h2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) hd_q[0] <= hd0_d;
  end

  // One quotient bit per stage
  for (genvar s = 0; s < QBits; s++) begin : g_div
    logic [32:0] r2;
    hd_t hd_d;
    always_comb begin
      r2       = {hd_q[s].rem, hd_q[s].low[QBits-1]};
      hd_d     = hd_q[s];
      hd_d.low = {hd_q[s].low[QBits-2:0], 1'b0};
      if (r2 >= {1'b0, cfg_i.scale}) begin
        hd_d.rem = 32'(r2 - {1'b0, cfg_i.scale});
        hd_d.quo = {hd_q[s].quo[QBits-2:0], 1'b1};
      end else begin
        hd_d.rem = r2[31:0];
        hd_d.quo = {hd_q[s].quo[QBits-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) hv_q[s+1] <= 1'b0;
      else if (en_i) hv_q[s+1] <= hv_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) hd_q[s+1] <= hd_d;
    end
  end

  assign valid_o = hv_q[QBits];
  assign side_o  = hd_q[QBits].side;
  assign ovf_o   = hd_q[QBits].ovf;
  assign quo_o   = hd_q[QBits].quo;

endmodule
